@@ sv/lfb_pkg.sv @@
package lfb_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [7:0]  FRAME_HEAD = 8'h55;
    localparam logic [7:0]  FRAME_TAIL = 8'hAA;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] frame_length;
        logic        first_byte;
        logic        last_byte;
        logic        empty_frame;
    } t_in_word;

    // one framer decision: which sections of the frame this input word produces
    typedef struct packed {
        logic        has_head;
        logic        has_data;
        logic        has_trail;
        logic [15:0] len;
        logic [7:0]  data;
        logic [31:0] crc;
    } t_job;

    typedef enum logic [9:0] {
        SLOT_HEAD   = 10'b00_0000_0001,
        SLOT_ID     = 10'b00_0000_0010,
        SLOT_LEN_LO = 10'b00_0000_0100,
        SLOT_LEN_HI = 10'b00_0000_1000,
        SLOT_DATA   = 10'b00_0001_0000,
        SLOT_CRC0   = 10'b00_0010_0000,
        SLOT_CRC1   = 10'b00_0100_0000,
        SLOT_CRC2   = 10'b00_1000_0000,
        SLOT_CRC3   = 10'b01_0000_0000,
        SLOT_TAIL   = 10'b10_0000_0000
    } t_slot;

    // reflected CRC-32, one byte, unrolled
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ sv/lfb_if.sv @@
interface lfb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
    logic        first_byte;
    logic        last_byte;
    logic        empty_frame;

    modport source (
        output valid, payload_byte, frame_length, first_byte, last_byte, empty_frame,
        input  ready
    );
    modport sink (
        input  valid, payload_byte, frame_length, first_byte, last_byte, empty_frame,
        output ready
    );
endinterface

interface lfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_frame;

    modport source (output valid, out_byte, end_of_frame, input ready);
    modport sink   (input valid, out_byte, end_of_frame, output ready);
endinterface

@@ sv/lfb_framer.sv @@
module lfb_framer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lfb_in_if.sink        i_in,
    output lfb_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_take
);

    logic             r_in_valid;
    lfb_pkg::t_in_word r_in;
    logic [31:0]      r_crc;
    logic             r_inside;

    logic [31:0]      n_crc;
    logic             n_inside;
    logic [31:0]      w_base;
    logic [31:0]      w_fold;
    logic             w_stray;
    logic             w_consume;
    logic             w_accept;

    assign w_stray     = r_in_valid && !r_in.empty_frame && !r_in.first_byte && !r_inside;
    assign o_job_valid = r_in_valid && !w_stray;
    assign w_consume   = (o_job_valid && i_job_take) || w_stray;
    assign i_in.ready  = !r_in_valid || w_consume;
    assign w_accept    = i_in.valid && i_in.ready;

    assign w_base = r_in.first_byte ? lfb_pkg::CRC_INIT : r_crc;
    assign w_fold = lfb_pkg::crc_fold(w_base, r_in.payload_byte);

    always_comb begin
        if (r_in.empty_frame) begin
            o_job.has_head  = 1'b1;
            o_job.has_data  = 1'b0;
            o_job.has_trail = 1'b1;
            o_job.len       = 16'h0000;
            o_job.data      = r_in.payload_byte;
            o_job.crc       = 32'h0000_0000;
            n_crc           = lfb_pkg::CRC_INIT;
            n_inside        = 1'b0;
        end else begin
            o_job.has_head  = r_in.first_byte;
            o_job.has_data  = 1'b1;
            o_job.has_trail = r_in.last_byte;
            o_job.len       = r_in.frame_length;
            o_job.data      = r_in.payload_byte;
            o_job.crc       = ~w_fold;
            n_crc           = r_in.last_byte ? lfb_pkg::CRC_INIT : w_fold;
            n_inside        = !r_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_crc      <= lfb_pkg::CRC_INIT;
            r_inside   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_consume) begin
                r_in_valid <= 1'b0;
            end
            if (w_consume && !w_stray) begin
                r_crc    <= n_crc;
                r_inside <= n_inside;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.payload_byte <= i_in.payload_byte;
            r_in.frame_length <= i_in.frame_length;
            r_in.first_byte   <= i_in.first_byte;
            r_in.last_byte    <= i_in.last_byte;
            r_in.empty_frame  <= i_in.empty_frame;
        end
    end

    a_idle_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside |-> r_crc == lfb_pkg::CRC_INIT)
        else $error("crc not at init outside a frame");

    a_stray_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stray |=> $stable(r_crc) && $stable(r_inside))
        else $error("stray word changed frame state");

endmodule

@@ sv/lfb_emitter.sv @@
module lfb_emitter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_node_id,
    input  lfb_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_take,
    lfb_out_if.source     o_out
);

    logic            r_valid;
    lfb_pkg::t_job   r_job;
    lfb_pkg::t_slot  r_slot;

    lfb_pkg::t_slot  w_next;
    lfb_pkg::t_slot  w_start;
    logic            w_last;
    logic            w_advance;

    assign w_advance  = r_valid && o_out.ready;
    assign o_job_take = i_job_valid && (!r_valid || (w_advance && w_last));
    assign w_start    = i_job.has_head ? lfb_pkg::SLOT_HEAD : lfb_pkg::SLOT_DATA;

    always_comb begin
        w_next = lfb_pkg::SLOT_TAIL;
        w_last = 1'b0;
        case (r_slot)
            lfb_pkg::SLOT_HEAD:   w_next = lfb_pkg::SLOT_ID;
            lfb_pkg::SLOT_ID:     w_next = lfb_pkg::SLOT_LEN_LO;
            lfb_pkg::SLOT_LEN_LO: w_next = lfb_pkg::SLOT_LEN_HI;
            lfb_pkg::SLOT_LEN_HI: w_next = r_job.has_data ? lfb_pkg::SLOT_DATA
                                                          : lfb_pkg::SLOT_CRC0;
            lfb_pkg::SLOT_DATA: begin
                w_next = lfb_pkg::SLOT_CRC0;
                w_last = !r_job.has_trail;
            end
            lfb_pkg::SLOT_CRC0:   w_next = lfb_pkg::SLOT_CRC1;
            lfb_pkg::SLOT_CRC1:   w_next = lfb_pkg::SLOT_CRC2;
            lfb_pkg::SLOT_CRC2:   w_next = lfb_pkg::SLOT_CRC3;
            lfb_pkg::SLOT_CRC3:   w_next = lfb_pkg::SLOT_TAIL;
            lfb_pkg::SLOT_TAIL:   w_last = 1'b1;
            default:              w_last = 1'b1;
        endcase
    end

    always_comb begin
        case (r_slot)
            lfb_pkg::SLOT_HEAD:   o_out.out_byte = lfb_pkg::FRAME_HEAD;
            lfb_pkg::SLOT_ID:     o_out.out_byte = i_node_id;
            lfb_pkg::SLOT_LEN_LO: o_out.out_byte = r_job.len[7:0];
            lfb_pkg::SLOT_LEN_HI: o_out.out_byte = r_job.len[15:8];
            lfb_pkg::SLOT_DATA:   o_out.out_byte = r_job.data;
            lfb_pkg::SLOT_CRC0:   o_out.out_byte = r_job.crc[7:0];
            lfb_pkg::SLOT_CRC1:   o_out.out_byte = r_job.crc[15:8];
            lfb_pkg::SLOT_CRC2:   o_out.out_byte = r_job.crc[23:16];
            lfb_pkg::SLOT_CRC3:   o_out.out_byte = r_job.crc[31:24];
            lfb_pkg::SLOT_TAIL:   o_out.out_byte = lfb_pkg::FRAME_TAIL;
            default:              o_out.out_byte = lfb_pkg::FRAME_TAIL;
        endcase
    end

    assign o_out.valid        = r_valid;
    assign o_out.end_of_frame = (r_slot == lfb_pkg::SLOT_TAIL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= lfb_pkg::SLOT_HEAD;
        end else begin
            if (o_job_take) begin
                r_valid <= 1'b1;
                r_slot  <= w_start;
            end else if (w_advance) begin
                if (w_last) begin
                    r_valid <= 1'b0;
                end else begin
                    r_slot <= w_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
        end
    end

    a_slot_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_slot))
        else $error("slot pointer not one-hot");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_last && !i_job_valid |=> !r_valid)
        else $error("emitter kept a finished word sequence");

endmodule

@@ sv/link_frame_builder_crc32.sv @@
// Length-prefixed framer with reflected CRC-32.
// i_in (valid/ready) carries payload words with first/last/empty flags and the
// frame length; o_out (valid/ready) carries the framed byte stream, with
// end_of_frame high on the tail byte. i_cfg_we/i_cfg_wdata load the node id;
// the user writes it only while the block is idle; the block does not enforce it.
// A frame start emits header 0x55, node id and length (low byte first) ahead of
// the payload byte; a last word adds the inverted CRC (low byte first) and 0xAA.
// An empty frame emits header, node id, zero length, a zero CRC and 0xAA.
// An accepted word passes the input register, then the output sequencer register.
// Throughput: one output word per cycle while o_out is ready; an input word makes
// 1 output word mid-frame, 5 as first, 6 as last, 10 as a single-word frame and
// 9 as an empty frame. Stray words outside a frame are dropped without output.
// The input register takes the next word while the sequencer still drains the
// current one; a stall on o_out backs up into i_in.ready after that one word.
// Reset (i_rst_n low, synchronous) empties both registers, sets the CRC to all
// ones, closes any open frame and clears the node id to zero.
module link_frame_builder_crc32 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    lfb_in_if.sink     i_in,
    lfb_out_if.source  o_out
);

    logic [7:0]    r_node_id;
    lfb_pkg::t_job w_job;
    logic          w_job_valid;
    logic          w_job_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= 8'h00;
        end else if (i_cfg_we) begin
            r_node_id <= i_cfg_wdata;
        end
    end

    lfb_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_take  (w_job_take)
    );

    lfb_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_node_id   (r_node_id),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_take  (w_job_take),
        .o_out       (o_out)
    );

endmodule

@@ verif/link_frame_builder_crc32_test.sv @@
module link_frame_builder_crc32_test;

    localparam logic [31:0] CRC_SEED    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_REFL    = 32'hEDB8_8320;
    localparam logic [7:0]  HEAD_BYTE   = 8'h55;
    localparam logic [7:0]  TAIL_BYTE   = 8'hAA;
    localparam int          HOLD_CYCLES = 150;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [7:0] value;
        logic       eof;
    } t_frame_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    lfb_in_if  in_ch();
    lfb_out_if out_ch();

    link_frame_builder_crc32 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    lfb_pkg::t_in_word payload_q[$];
    t_frame_word       framed_q[$];
    lfb_pkg::t_in_word offered;

    logic [31:0] crc_run    = CRC_SEED;
    logic        frame_open = 1'b0;
    logic [7:0]  node_id    = 8'h00;

    int words_loaded   = 0;
    int words_taken    = 0;
    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ d[i];
            r = r >> 1;
            if (fb) begin
                r = r ^ CRC_REFL;
            end
        end
        return r;
    endfunction

    task automatic emit(input logic [7:0] value, input logic eof);
        t_frame_word w;
        w.value = value;
        w.eof   = eof;
        framed_q.push_back(w);
    endtask

    task automatic emit_head(input logic [15:0] len);
        emit(HEAD_BYTE, 1'b0);
        emit(node_id, 1'b0);
        emit(len[7:0], 1'b0);
        emit(len[15:8], 1'b0);
    endtask

    task automatic emit_trail(input logic [31:0] crc);
        emit(crc[7:0], 1'b0);
        emit(crc[15:8], 1'b0);
        emit(crc[23:16], 1'b0);
        emit(crc[31:24], 1'b0);
        emit(TAIL_BYTE, 1'b1);
    endtask

    task automatic frame_predict(input lfb_pkg::t_in_word w);
        if (w.empty_frame) begin
            emit_head(16'h0000);
            emit_trail(32'h0000_0000);
            crc_run    = CRC_SEED;
            frame_open = 1'b0;
        end else if (w.first_byte || frame_open) begin
            if (w.first_byte) begin
                emit_head(w.frame_length);
                crc_run    = CRC_SEED;
                frame_open = 1'b1;
            end
            emit(w.payload_byte, 1'b0);
            crc_run = crc32_step(crc_run, w.payload_byte);
            if (w.last_byte) begin
                emit_trail(~crc_run);
                crc_run    = CRC_SEED;
                frame_open = 1'b0;
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                frame_predict(offered);
                words_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (payload_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = payload_q.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.payload_byte <= offered.payload_byte;
                    in_ch.frame_length <= offered.frame_length;
                    in_ch.first_byte   <= offered.first_byte;
                    in_ch.last_byte    <= offered.last_byte;
                    in_ch.empty_frame  <= offered.empty_frame;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_frame_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (framed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: out_byte %h end_of_frame %b",
                             out_ch.out_byte, out_ch.end_of_frame);
                end
            end else begin
                want = framed_q.pop_front();
                if (out_ch.out_byte !== want.value || out_ch.end_of_frame !== want.eof) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected out_byte %h end_of_frame %b, got %h %b",
                                 want.value, want.eof, out_ch.out_byte, out_ch.end_of_frame);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic add_word(input logic [7:0] data, input logic [15:0] len,
                            input logic first, input logic last, input logic empty);
        lfb_pkg::t_in_word w;
        w.payload_byte = data;
        w.frame_length = len;
        w.first_byte   = first;
        w.last_byte    = last;
        w.empty_frame  = empty;
        payload_q.push_back(w);
        words_loaded++;
    endtask

    task automatic put_frame(input int n_bytes, input logic closed);
        logic [15:0] len;
        len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            add_word(8'($urandom), len, i == 0, closed && (i == n_bytes - 1), 1'b0);
        end
    endtask

    task automatic load_traffic(input int n_words);
        int target;
        int kind;
        target = words_loaded + n_words;
        while (words_loaded < target) begin
            kind = $urandom_range(9);
            if (kind <= 5) begin
                put_frame(($urandom_range(7) == 0) ? $urandom_range(24, 7)
                                                   : $urandom_range(1, 6), 1'b1);
            end else if (kind == 6) begin
                add_word(8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), 1'b1);
            end else if (kind == 7) begin
                add_word(8'($urandom), 16'($urandom), 1'b0, 1'($urandom), 1'b0);
            end else if (kind == 8) begin
                put_frame($urandom_range(1, 4), 1'b0);
            end else begin
                add_word(8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                         $urandom_range(7) == 0);
            end
        end
    endtask

    task automatic drain;
        while (words_taken != words_loaded || framed_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_node_id(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        node_id = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] id, input int idle_pct, input int stall_pct,
                             input int n_words);
        write_node_id(id);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        load_traffic(n_words);
        drain();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 8'h00;
        in_ch.valid        = 1'b0;
        in_ch.payload_byte = 8'h00;
        in_ch.frame_length = 16'h0000;
        in_ch.first_byte   = 1'b0;
        in_ch.last_byte    = 1'b0;
        in_ch.empty_frame  = 1'b0;
        out_ch.ready       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, empty frames, abandoned frames, stray words
        write_node_id(8'hFF);
        add_word(8'h00, 16'h0000, 1'b1, 1'b1, 1'b0);
        add_word(8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
        add_word(8'h31, 16'h0003, 1'b1, 1'b0, 1'b0);
        add_word(8'h32, 16'h0003, 1'b0, 1'b0, 1'b0);
        add_word(8'h33, 16'h0003, 1'b0, 1'b1, 1'b0);
        add_word(8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
        add_word(8'hA5, 16'h00FF, 1'b0, 1'b1, 1'b0);
        add_word(8'h5A, 16'hFF00, 1'b0, 1'b0, 1'b0);
        add_word(8'h01, 16'h00FF, 1'b1, 1'b0, 1'b0);
        add_word(8'h80, 16'h0000, 1'b0, 1'b0, 1'b0);
        add_word(8'h7F, 16'hFF00, 1'b1, 1'b0, 1'b0);
        add_word(8'hC3, 16'h0000, 1'b0, 1'b1, 1'b0);
        add_word(8'h11, 16'h1234, 1'b1, 1'b0, 1'b0);
        add_word(8'h22, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_word(8'h33, 16'h0000, 1'b0, 1'b1, 1'b0);
        add_word(8'h00, 16'h0000, 1'b0, 1'b0, 1'b1);
        add_word(8'hAA, 16'hAAAA, 1'b1, 1'b1, 1'b0);
        add_word(8'h55, 16'h5555, 1'b1, 1'b1, 1'b0);
        drain();

        run_phase(8'h00, 0, 0, 40);
        run_phase(8'($urandom), 82, 0, 35);
        run_phase(8'h80, 0, 82, 35);
        run_phase(8'h01, 28, 28, 40);

        // long receiver hold-off while the sender keeps offering
        write_node_id(8'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        load_traffic(30);
        drain();

        if (mismatches == 0 && framed_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (framed_q.size() != 0) begin
                $display("expected words never seen: %0d", framed_q.size());
            end
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
